@@ hw/rtl/pfk_pkg.sv @@
// Shared widths, constants, types and helpers for the planar arm forward kinematics block.
package pfk_pkg;

   localparam int unsigned POS_W        = 24;
   localparam int unsigned ANG_W        = 16;
   localparam int unsigned LEN_W        = 20;
   localparam int unsigned PAD_W        = 16;
   localparam int unsigned CNT_W        = 4;
   localparam int unsigned GAIN_W       = 16;
   localparam int unsigned ACC_W        = 38;
   localparam int unsigned OFS_W        = ACC_W - 16;
   localparam int unsigned SUM_W        = POS_W + 2;
   localparam int unsigned ATAN_W       = 14;
   localparam int unsigned ATAN_ENTRIES = 24;
   localparam int unsigned CSR_IDX_W    = 4;

   localparam int unsigned MAX_SEGMENTS = 8;
   localparam int unsigned CORDIC_STEPS = 16;

   // 1/K of the rotation in Q.16
   localparam logic [GAIN_W-1:0] GAIN_Q16 = 16'd39797;
   localparam logic [PAD_W-1:0]  PAD_RESET = 16'd3584;

   localparam logic [CSR_IDX_W-1:0] REG_BASE_X       = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_Y       = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_HEADING = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_OFFSET   = 4'd3;

   typedef struct packed {
      logic                    start;
      logic signed [LEN_W-1:0] mag;
      logic [ANG_W-1:0]        angle;
   } rot_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [OFS_W-1:0] ox;
      logic signed [OFS_W-1:0] oy;
   } rot_rsp_type;

   // Arctangent of 2^-i in binary-angle units, rounded
   function automatic logic [ATAN_W-1:0] atan_lookup(input logic [4:0] idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         5'd0:    v = 14'd8192;
         5'd1:    v = 14'd4836;
         5'd2:    v = 14'd2555;
         5'd3:    v = 14'd1297;
         5'd4:    v = 14'd651;
         5'd5:    v = 14'd326;
         5'd6:    v = 14'd163;
         5'd7:    v = 14'd81;
         5'd8:    v = 14'd41;
         5'd9:    v = 14'd20;
         5'd10:   v = 14'd10;
         5'd11:   v = 14'd5;
         5'd12:   v = 14'd3;
         5'd13:   v = 14'd1;
         5'd14:   v = 14'd1;
         default: v = 14'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > $signed({{(SUM_W-POS_W){1'b0}}, 1'b0, {(POS_W-1){1'b1}}})) begin
         r = {1'b0, {(POS_W-1){1'b1}}};
      end else if (v < $signed({{(SUM_W-POS_W){1'b1}}, 1'b1, {(POS_W-1){1'b0}}})) begin
         r = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/pfk_cordic.sv @@
// Iterative CORDIC rotation of (mag, 0) through a binary angle, one micro-rotation per cycle.
module pfk_cordic #(
   parameter int unsigned STEPS = pfk_pkg::CORDIC_STEPS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pfk_pkg::rot_req_type req,
   output pfk_pkg::rot_rsp_type rsp
);

   localparam int unsigned IDX_W = $clog2(STEPS);
   localparam int unsigned Z_W   = 18;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STEPS - 1);

   localparam logic [1:0] C_IDLE  = 2'd0;
   localparam logic [1:0] C_SCALE = 2'd1;
   localparam logic [1:0] C_ITER  = 2'd2;
   localparam logic [1:0] C_ROUND = 2'd3;

   logic [1:0]                           state_ff, state_in;
   logic signed [pfk_pkg::LEN_W-1:0]     mag_ff, mag_in;
   logic                                 flip_ff, flip_in;
   logic signed [Z_W-1:0]                z_ff, z_in;
   logic signed [pfk_pkg::ACC_W-1:0]     x_ff, x_in, y_ff, y_in;
   logic [IDX_W-1:0]                     idx_ff, idx_in;
   logic                                 done_ff, done_in;
   logic signed [pfk_pkg::OFS_W-1:0]     ox_ff, ox_in, oy_ff, oy_in;

   logic signed [Z_W-1:0]                z_start;
   logic signed [pfk_pkg::LEN_W+pfk_pkg::GAIN_W:0] prod;
   logic signed [pfk_pkg::ACC_W-1:0]     prod_ext, dx, dy, x_rnd, y_rnd;
   logic signed [Z_W-1:0]                atan_ext;

   always_comb begin
      z_start  = Z_W'($signed(req.angle));
      prod     = mag_ff * $signed({1'b0, pfk_pkg::GAIN_Q16});
      prod_ext = pfk_pkg::ACC_W'(prod);
      dx       = y_ff >>> idx_ff;
      dy       = x_ff >>> idx_ff;
      atan_ext = $signed({{(Z_W-pfk_pkg::ATAN_W){1'b0}},
                          pfk_pkg::atan_lookup(5'(idx_ff))});
      x_rnd    = x_ff + pfk_pkg::ACC_W'(32768);
      y_rnd    = y_ff + pfk_pkg::ACC_W'(32768);

      state_in = state_ff;
      mag_in   = mag_ff;
      flip_in  = flip_ff;
      z_in     = z_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      idx_in   = idx_ff;
      done_in  = 1'b0;
      ox_in    = ox_ff;
      oy_in    = oy_ff;

      unique case (state_ff)
         C_IDLE: begin
            if (req.start) begin
               mag_in   = req.mag;
               state_in = C_SCALE;
               // fold the angle into the right half plane
               if (z_start >= Z_W'(16384)) begin
                  z_in    = z_start - Z_W'(32768);
                  flip_in = 1'b1;
               end else if (z_start < -Z_W'(16384)) begin
                  z_in    = z_start + Z_W'(32768);
                  flip_in = 1'b1;
               end else begin
                  z_in    = z_start;
                  flip_in = 1'b0;
               end
            end
         end
         C_SCALE: begin
            x_in     = flip_ff ? -prod_ext : prod_ext;
            y_in     = '0;
            idx_in   = '0;
            state_in = C_ITER;
         end
         C_ITER: begin
            if (z_ff >= 0) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_ext;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_ext;
            end
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               state_in = C_ROUND;
            end
         end
         C_ROUND: begin
            ox_in    = x_rnd[pfk_pkg::ACC_W-1:16];
            oy_in    = y_rnd[pfk_pkg::ACC_W-1:16];
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      mag_ff  <= mag_in;
      flip_ff <= flip_in;
      z_ff    <= z_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      idx_ff  <= idx_in;
      ox_ff   <= ox_in;
      oy_ff   <= oy_in;
   end

   assign rsp.done = done_ff;
   assign rsp.ox   = ox_ff;
   assign rsp.oy   = oy_ff;

endmodule

@@ hw/rtl/planar_arm_forward_kinematics.sv @@
// Planar arm forward kinematics: segment words in, joint and grabber pad points out.
//
// Each request word is one arm segment (relative angle, signed length, first flag in tuser,
// last flag in tlast). The block adds the angle to the running heading, rotates the
// length through it with one shared iterative CORDIC unit, adds the offset to the previous
// joint with 24-bit saturation and sends the joint point. On a last segment of nonzero
// length it runs the same unit again on the pad offset and sends the grabber pad point.
// The CORDIC unit sets the rate unless the output stalls. Only one segment is in work at a
// time; req_tready is low from acceptance until the block is ready again, and a result
// waits in the output register while the rotation runs.
module planar_arm_forward_kinematics #(
   parameter int unsigned CORDIC_STEPS = pfk_pkg::CORDIC_STEPS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [15:0] seg_angle, [35:16] seg_length, [39:36] zero
   input  logic [0:0]  req_tuser,   // [0] first_segment
   input  logic        req_tlast,   // last_segment
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [23:0] point_x, [47:24] point_y, [51:48] joint_number
   output logic [0:0]  rsp_tuser,   // [0] point_kind
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [pfk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pfk_pkg::POS_W-1:0]     csr_data
);

   localparam int unsigned POS_W = pfk_pkg::POS_W;
   localparam int unsigned ANG_W = pfk_pkg::ANG_W;
   localparam int unsigned LEN_W = pfk_pkg::LEN_W;
   localparam int unsigned PAD_W = pfk_pkg::PAD_W;
   localparam int unsigned CNT_W = pfk_pkg::CNT_W;
   localparam int unsigned SUM_W = pfk_pkg::SUM_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(pfk_pkg::MAX_SEGMENTS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ROT  = 2'd1;
   localparam logic [1:0] S_OUT  = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic signed [POS_W-1:0]   base_x_ff, base_y_ff;
   logic [ANG_W-1:0]          base_head_ff;
   logic [PAD_W-1:0]          pad_off_ff;
   logic [ANG_W-1:0]          heading_ff, heading_in;
   logic signed [POS_W-1:0]   joint_x_ff, joint_x_in, joint_y_ff, joint_y_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [LEN_W-1:0]   len_ff, len_in;
   logic                      pad_pend_ff, pad_pend_in;
   logic                      phase_pad_ff, phase_pad_in;
   logic signed [POS_W-1:0]   pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [CNT_W-1:0]          rsp_num_ff, rsp_num_in;
   logic                      rsp_kind_ff, rsp_kind_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [ANG_W-1:0]          seg_angle;
   logic signed [LEN_W-1:0]   seg_length;
   logic                      first_segment, last_segment;
   logic                      accept, slot_free, pad_start;
   logic [ANG_W-1:0]          heading_acc;
   logic signed [LEN_W-1:0]   pad_mag;
   logic signed [SUM_W-1:0]   sum_x, sum_y;
   logic signed [POS_W-1:0]   sat_x, sat_y;
   pfk_pkg::rot_req_type      rot_req;
   pfk_pkg::rot_rsp_type      rot_rsp;

   assign seg_angle     = req_tdata[15:0];
   assign seg_length    = $signed(req_tdata[35:16]);
   assign first_segment = req_tuser[0];
   assign last_segment  = req_tlast;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   pfk_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (rot_req),
      .rsp   (rot_rsp)
   );

   always_comb begin
      heading_acc = (first_segment ? base_head_ff : heading_ff) + seg_angle;
      pad_mag     = (len_ff < 0) ? -LEN_W'($signed({1'b0, pad_off_ff}))
                                 :  LEN_W'($signed({1'b0, pad_off_ff}));
      pad_start   = (state_ff == S_OUT) && slot_free && pad_pend_ff && !phase_pad_ff;

      rot_req.start = accept || pad_start;
      rot_req.mag   = accept ? seg_length : pad_mag;
      rot_req.angle = accept ? heading_acc : heading_ff;

      sum_x = SUM_W'(joint_x_ff) + SUM_W'(rot_rsp.ox);
      sum_y = SUM_W'(joint_y_ff) + SUM_W'(rot_rsp.oy);
      sat_x = pfk_pkg::sat_pos(sum_x);
      sat_y = pfk_pkg::sat_pos(sum_y);
   end

   always_comb begin
      state_in     = state_ff;
      heading_in   = heading_ff;
      joint_x_in   = joint_x_ff;
      joint_y_in   = joint_y_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      pad_pend_in  = pad_pend_ff;
      phase_pad_in = phase_pad_ff;
      pt_x_in      = pt_x_ff;
      pt_y_in      = pt_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               heading_in   = heading_acc;
               len_in       = seg_length;
               pad_pend_in  = last_segment && (seg_length != 0);
               phase_pad_in = 1'b0;
               if (first_segment) begin
                  joint_x_in = base_x_ff;
                  joint_y_in = base_y_ff;
                  count_in   = CNT_W'(1);
               end else if (count_ff < MAX_CNT) begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = S_ROT;
            end
         end
         S_ROT: begin
            if (rot_rsp.done) begin
               pt_x_in = sat_x;
               pt_y_in = sat_y;
               // the pad point starts from the new joint and leaves it alone
               if (!phase_pad_ff) begin
                  joint_x_in = sat_x;
                  joint_y_in = sat_y;
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = pt_x_ff;
               rsp_y_in     = pt_y_ff;
               rsp_num_in   = count_ff;
               rsp_kind_in  = phase_pad_ff;
               rsp_last_in  = phase_pad_ff || !pad_pend_ff;
               if (pad_start) begin
                  phase_pad_in = 1'b1;
                  state_in     = S_ROT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_x_ff    <= '0;
         base_y_ff    <= '0;
         base_head_ff <= '0;
         pad_off_ff   <= pfk_pkg::PAD_RESET;
         heading_ff   <= '0;
         joint_x_ff   <= '0;
         joint_y_ff   <= '0;
         count_ff     <= '0;
         pad_pend_ff  <= 1'b0;
         phase_pad_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heading_ff   <= heading_in;
         joint_x_ff   <= joint_x_in;
         joint_y_ff   <= joint_y_in;
         count_ff     <= count_in;
         pad_pend_ff  <= pad_pend_in;
         phase_pad_ff <= phase_pad_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               pfk_pkg::REG_BASE_X:       base_x_ff    <= csr_data;
               pfk_pkg::REG_BASE_Y:       base_y_ff    <= csr_data;
               pfk_pkg::REG_BASE_HEADING: base_head_ff <= csr_data[ANG_W-1:0];
               pfk_pkg::REG_PAD_OFFSET:   pad_off_ff   <= csr_data[PAD_W-1:0];
               default: ;
            endcase
         end
      end
      len_ff      <= len_in;
      pt_x_ff     <= pt_x_in;
      pt_y_ff     <= pt_y_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_num_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_done_in_rot: assert property (@(posedge clock) disable iff (reset)
      rot_rsp.done |-> (state_ff == S_ROT))
      else $error("rotation finished outside of the rotate state");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("segment count above maximum");

   a_pad_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff) |-> rsp_last_ff)
      else $error("pad point not marked last of run");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("ready right after accepting a segment");

endmodule

@@ test/pfk_checker.sv @@
// Checker for the planar arm block: predicts joint and pad points and compares the result stream.
module pfk_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [39:0]                   req_tdata,   // [15:0] seg_angle, [35:16] seg_length
   input  logic [0:0]                    req_tuser,   // [0] first_segment
   input  logic                          req_tlast,   // last_segment
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [55:0]                   rsp_tdata,   // [23:0] x, [47:24] y, [51:48] joint_number
   input  logic [0:0]                    rsp_tuser,   // [0] point_kind
   input  logic                          rsp_tlast,   // last_of_run
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [pfk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pfk_pkg::POS_W-1:0]     csr_data,
   output int unsigned                   fail_count,
   output int unsigned                   pending
);

   localparam logic   KIND_JOINT = 1'b0;
   localparam logic   KIND_PAD   = 1'b1;
   localparam longint POS_HI     = 64'sd8388607;
   localparam longint POS_LO     = -64'sd8388608;

   typedef struct packed {
      logic [23:0] x;
      logic [23:0] y;
      logic        kind;
      logic [3:0]  num;
      logic        closes;
   } arm_point_type;

   arm_point_type expected_points[$];
   int unsigned   errors = 0;

   // register copies
   longint        base_px, base_py, pad_dist;
   logic [15:0]   base_dir;
   // chain state
   logic [15:0]   heading;
   longint        joint_px, joint_py;
   logic [3:0]    seg_count;

   assign fail_count = errors;

   task automatic report_mismatch(input string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   function automatic int arctan_step(input int i);
      int v;
      case (i)
         0:       v = 8192;
         1:       v = 4836;
         2:       v = 2555;
         3:       v = 1297;
         4:       v = 651;
         5:       v = 326;
         6:       v = 163;
         7:       v = 81;
         8:       v = 41;
         9:       v = 20;
         10:      v = 10;
         11:      v = 5;
         12:      v = 3;
         13, 14:  v = 1;
         default: v = 0;
      endcase
      return v;
   endfunction

   function automatic longint clamp_pos(input longint v);
      if (v > POS_HI) return POS_HI;
      if (v < POS_LO) return POS_LO;
      return v;
   endfunction

   // Rotate (mag, 0) through binary angle dir, gain removed up front.
   function automatic void cordic_rotate(input longint mag, input logic [15:0] dir,
                                         output longint ox, output longint oy);
      longint x, y, dx, dy;
      int     z, i;
      x = mag * longint'(pfk_pkg::GAIN_Q16);
      y = 0;
      z = int'($signed(dir));
      // fold into the right half plane
      if (z >= 16384) begin
         z -= 32768;
         x = -x;
      end else if (z < -16384) begin
         z += 32768;
         x = -x;
      end
      for (i = 0; i < pfk_pkg::CORDIC_STEPS && i < pfk_pkg::ATAN_ENTRIES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= arctan_step(i);
         end else begin
            x += dx;
            y -= dy;
            z += arctan_step(i);
         end
      end
      ox = (x + 64'sd32768) >>> 16;
      oy = (y + 64'sd32768) >>> 16;
   endfunction

   task automatic predict_segment(input logic [15:0] ang, input longint len,
                                  input logic first, input logic last);
      longint        ox, oy;
      logic          has_pad;
      arm_point_type pt;
      if (first) begin
         joint_px  = base_px;
         joint_py  = base_py;
         heading   = base_dir + ang;
         seg_count = 4'd1;
      end else begin
         heading = heading + ang;
         if (seg_count < pfk_pkg::MAX_SEGMENTS) seg_count++;
      end
      cordic_rotate(len, heading, ox, oy);
      joint_px = clamp_pos(joint_px + ox);
      joint_py = clamp_pos(joint_py + oy);
      has_pad  = last && (len != 0);
      pt.x      = joint_px[23:0];
      pt.y      = joint_py[23:0];
      pt.kind   = KIND_JOINT;
      pt.num    = seg_count;
      pt.closes = !has_pad;
      expected_points = {expected_points, pt};
      if (has_pad) begin
         // pad follows the segment's actual direction
         cordic_rotate((len < 0) ? -pad_dist : pad_dist, heading, ox, oy);
         pt.x      = 24'(clamp_pos(joint_px + ox));
         pt.y      = 24'(clamp_pos(joint_py + oy));
         pt.kind   = KIND_PAD;
         pt.closes = 1'b1;
         expected_points = {expected_points, pt};
      end
   endtask

   always @(posedge clock) begin : watch
      arm_point_type got, want;
      if (reset) begin
         base_px   = 0;
         base_py   = 0;
         base_dir  = '0;
         pad_dist  = longint'(pfk_pkg::PAD_RESET);
         heading   = '0;
         joint_px  = 0;
         joint_py  = 0;
         seg_count = '0;
         expected_points.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pfk_pkg::REG_BASE_X:       base_px  = longint'($signed(csr_data));
               pfk_pkg::REG_BASE_Y:       base_py  = longint'($signed(csr_data));
               pfk_pkg::REG_BASE_HEADING: base_dir = csr_data[15:0];
               pfk_pkg::REG_PAD_OFFSET:   pad_dist = longint'(csr_data[15:0]);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.x      = rsp_tdata[23:0];
            got.y      = rsp_tdata[47:24];
            got.num    = rsp_tdata[51:48];
            got.kind   = rsp_tuser[0];
            got.closes = rsp_tlast;
            if (expected_points.size() == 0) begin
               report_mismatch($sformatf("unexpected point word x=%0d y=%0d",
                               $signed(got.x), $signed(got.y)));
            end else begin
               want = expected_points.pop_front();
               if (got.x !== want.x)
                  report_mismatch($sformatf("point_x got %0d expected %0d",
                                  $signed(got.x), $signed(want.x)));
               if (got.y !== want.y)
                  report_mismatch($sformatf("point_y got %0d expected %0d",
                                  $signed(got.y), $signed(want.y)));
               if (got.kind !== want.kind)
                  report_mismatch($sformatf("point_kind got %0d expected %0d",
                                  got.kind, want.kind));
               if (got.num !== want.num)
                  report_mismatch($sformatf("joint_number got %0d expected %0d",
                                  got.num, want.num));
               if (got.closes !== want.closes)
                  report_mismatch($sformatf("last_of_run got %0d expected %0d",
                                  got.closes, want.closes));
            end
         end
         if (req_tvalid && req_tready)
            predict_segment(req_tdata[15:0], longint'($signed(req_tdata[35:16])),
                            req_tuser[0], req_tlast);
      end
      pending <= expected_points.size();
   end

endmodule

@@ test/tb_top.sv @@
// Top of the planar arm testbench: clock, reset, segment and register stimulus, verdict.
module tb_top;

   localparam logic [pfk_pkg::CSR_IDX_W-1:0] REG_SPARE = 4'd9;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [39:0]                   req_tdata;
   logic [0:0]                    req_tuser;
   logic                          req_tlast;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [55:0]                   rsp_tdata;
   logic [0:0]                    rsp_tuser;
   logic                          rsp_tlast;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [pfk_pkg::CSR_IDX_W-1:0] csr_index;
   logic [pfk_pkg::POS_W-1:0]     csr_data;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned send_gap_pct = 16;
   int unsigned recv_gap_pct = 70;
   int          hold_requests = 0;
   int          hold_served;
   int          hold_left;

   planar_arm_forward_kinematics u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   pfk_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

   // Result side: random stalls, plus a long hold-off on request.
   initial begin
      rsp_tready  = 1'b0;
      hold_served = 0;
      hold_left   = 0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_gap_pct);
         end
      end
   end

   // Leave valid high on return so back-to-back words need no second assignment.
   task automatic send_segment(input logic [15:0] ang, input logic [19:0] len,
                               input logic first, input logic last);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_gap_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, len, ang};
      req_tuser  <= first;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [pfk_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pfk_pkg::POS_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_setup(input logic [23:0] bx, input logic [23:0] by,
                              input logic [15:0] dir, input logic [15:0] pad);
      write_reg(pfk_pkg::REG_BASE_X, bx);
      write_reg(pfk_pkg::REG_BASE_Y, by);
      write_reg(pfk_pkg::REG_BASE_HEADING, {8'($urandom), dir});
      write_reg(pfk_pkg::REG_PAD_OFFSET, {8'($urandom), pad});
      write_reg(REG_SPARE, 24'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Drop valid, let every expected point arrive, then let the block idle before the next phase.
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic random_chains(input int n);
      int          sent, chain_len, k, pick;
      logic        first, last;
      logic [15:0] ang;
      logic [19:0] len;
      sent = 0;
      while (sent < n) begin
         chain_len = $urandom_range(9, 1);
         if ($urandom_range(19) == 0) chain_len = $urandom_range(14, 10);
         pick = $urandom_range(99);
         for (k = 0; k < chain_len; k++) begin
            // mostly well-formed chains; some start without first or never close
            first = (k == 0) ? (pick >= 8) : ($urandom_range(59) == 0);
            if (k == chain_len - 1) last = (pick < 8 || pick >= 13);
            else last = ($urandom_range(49) == 0);
            case ($urandom_range(9))
               0:       ang = 16'h0000;
               1:       ang = 16'h4000;
               2:       ang = 16'hC000;
               3:       ang = 16'h8000;
               4:       ang = ($urandom_range(1) != 0) ? 16'h3FFF : 16'hBFFF;
               default: ang = 16'($urandom);
            endcase
            case ($urandom_range(9))
               0:       len = '0;
               1, 2:    len = 20'($urandom);
               default: begin
                  len = 20'($urandom_range(16383));
                  if ($urandom_range(1) != 0) len = -len;
               end
            endcase
            if (sent == n / 3) hold_requests++;
            send_segment(ang, len, first, last);
            sent++;
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset registers; chain continues from the origin without a first segment
      send_segment(16'h0000, 20'd256, 1'b0, 1'b0);
      send_segment(16'h4000, 20'h80000, 1'b0, 1'b0);
      send_segment(16'h8000, 20'h7FFFF, 1'b1, 1'b1);
      // zero length on the last segment: no pad point
      send_segment(16'h7FFF, 20'd0, 1'b1, 1'b1);
      // negative length: pad lies opposite the heading
      send_segment(16'h2000, -20'sd1000, 1'b1, 1'b1);
      // ten segments: count saturates
      send_segment(16'h4000, 20'd5000, 1'b1, 1'b0);
      send_segment(16'hC000, 20'd5000, 1'b0, 1'b0);
      send_segment(16'hBFFF, 20'd5000, 1'b0, 1'b0);
      send_segment(16'h3FFF, -20'sd7000, 1'b0, 1'b0);
      send_segment(16'hFFFF, 20'd1, 1'b0, 1'b0);
      send_segment(16'h0001, 20'hFFFFF, 1'b0, 1'b0);
      send_segment(16'h1000, 20'd300, 1'b0, 1'b0);
      send_segment(16'hF000, 20'd12345, 1'b0, 1'b0);
      send_segment(16'h5555, 20'd777, 1'b0, 1'b0);
      send_segment(16'hAAAA, 20'h55555, 1'b0, 1'b1);
      drain();

      // extreme registers; the first word continues the old chain
      write_setup(24'h7FFFFF, 24'h800000, 16'h8000, 16'hFFFF);
      send_segment(16'h1234, 20'd300, 1'b0, 1'b0);
      send_segment(16'h8000, 20'h7FFFF, 1'b1, 1'b0);
      send_segment(16'h4000, 20'h80000, 1'b0, 1'b1);
      drain();
      write_setup(24'h800000, 24'h7FFFFF, 16'h7FFF, 16'h0000);
      send_segment(16'hFFFF, 20'h80000, 1'b1, 1'b1);
      send_segment(16'h0001, 20'h7FFFF, 1'b1, 1'b1);
      drain();

      write_setup(24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom));
      random_chains(330);
      drain();

      send_gap_pct = 70;
      recv_gap_pct = 16;
      write_setup(24'($urandom_range(65535)), -24'($urandom_range(65535)),
                  16'($urandom), 16'($urandom_range(8191)));
      random_chains(330);
      drain();

      send_gap_pct = 0;
      recv_gap_pct = 0;
      write_setup(24'd0, 24'd0, 16'd0, pfk_pkg::PAD_RESET);
      random_chains(340);
      drain();

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
